/* rtl/utf8v_pkg.sv */
// Shared types and constants for the restricted UTF-8 string validator.
// Depends on nothing; used by utf8v_step and utf8_string_validator_unit.
package utf8v_pkg;

    // Byte classification constants
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] DEL_BYTE   = 8'h7f;
    localparam logic [7:0] MASK_LEAD2 = 8'he0;
    localparam logic [7:0] CODE_LEAD2 = 8'hc0;
    localparam logic [7:0] MASK_LEAD3 = 8'hf0;
    localparam logic [7:0] CODE_LEAD3 = 8'he0;
    localparam logic [7:0] MASK_LEAD4 = 8'hf8;
    localparam logic [7:0] CODE_LEAD4 = 8'hf0;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    // Code point limits
    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] MIN_LEN1  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN2  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN3  = 21'h010000;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00dfff;

    // Continuation counts of a multi-byte sequence
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_ONE  = 2'd1;
    localparam logic [1:0] SEQ_TWO  = 2'd2;
    localparam logic [1:0] SEQ_THREE = 2'd3;

    // Per-string decoder state
    typedef struct packed {
        logic [1:0]      pending;
        logic [1:0]      seq_len;
        logic [CP_W-1:0] acc;
        logic            err;
    } dec_state_t;

endpackage

/* rtl/utf8v_step.sv */
// Combinational next-state and verdict logic for one byte transaction.
// Depends on utf8v_pkg.
module utf8v_step
(
    input  utf8v_pkg::dec_state_t state_cur,
    input  logic [7:0]            byte_in,
    input  logic                  last_in,
    input  logic                  none_in,
    output utf8v_pkg::dec_state_t state_nxt,
    output logic                  verdict
);

    utf8v_pkg::dec_state_t upd;
    logic [utf8v_pkg::CP_W-1:0] cp;
    logic [1:0]                 pend_dec;
    logic                       overlong;
    logic                       bad_cp;

    // Continuation assembly and final code point checks
    assign cp       = {state_cur.acc[utf8v_pkg::CP_W-7:0], byte_in[5:0]};
    assign pend_dec = state_cur.pending - 2'd1;
    assign overlong = (state_cur.seq_len == utf8v_pkg::SEQ_ONE   && cp < utf8v_pkg::MIN_LEN1) ||
                      (state_cur.seq_len == utf8v_pkg::SEQ_TWO   && cp < utf8v_pkg::MIN_LEN2) ||
                      (state_cur.seq_len == utf8v_pkg::SEQ_THREE && cp < utf8v_pkg::MIN_LEN3);
    assign bad_cp   = overlong || (cp > utf8v_pkg::MAX_CP) ||
                      (cp >= utf8v_pkg::SURR_LO && cp <= utf8v_pkg::SURR_HI);

    // Byte decode
    always_comb
    begin
        upd = state_cur;
        if (!none_in && !state_cur.err)
        begin
            if (state_cur.pending != 2'd0)
            begin
                if (byte_in[7:6] != utf8v_pkg::CONT_TAG)
                begin
                    upd.err = 1'b1;
                end
                else if (pend_dec != 2'd0)
                begin
                    upd.acc     = cp;
                    upd.pending = pend_dec;
                end
                else
                begin
                    upd.pending = 2'd0;
                    upd.seq_len = utf8v_pkg::SEQ_NONE;
                    upd.acc     = '0;
                    upd.err     = bad_cp;
                end
            end
            else if (!byte_in[7])
            begin
                // single-byte character: control codes and DEL are rejected
                if (byte_in < utf8v_pkg::CTRL_LIMIT || byte_in == utf8v_pkg::DEL_BYTE)
                begin
                    upd.err = 1'b1;
                end
            end
            else if ((byte_in & utf8v_pkg::MASK_LEAD2) == utf8v_pkg::CODE_LEAD2)
            begin
                upd.seq_len = utf8v_pkg::SEQ_ONE;
                upd.pending = utf8v_pkg::SEQ_ONE;
                upd.acc     = {{(utf8v_pkg::CP_W-5){1'b0}}, byte_in[4:0]};
            end
            else if ((byte_in & utf8v_pkg::MASK_LEAD3) == utf8v_pkg::CODE_LEAD3)
            begin
                upd.seq_len = utf8v_pkg::SEQ_TWO;
                upd.pending = utf8v_pkg::SEQ_TWO;
                upd.acc     = {{(utf8v_pkg::CP_W-4){1'b0}}, byte_in[3:0]};
            end
            else if ((byte_in & utf8v_pkg::MASK_LEAD4) == utf8v_pkg::CODE_LEAD4)
            begin
                upd.seq_len = utf8v_pkg::SEQ_THREE;
                upd.pending = utf8v_pkg::SEQ_THREE;
                upd.acc     = {{(utf8v_pkg::CP_W-3){1'b0}}, byte_in[2:0]};
            end
            else
            begin
                // stray continuation or 0xF8..0xFF as a lead byte
                upd.err = 1'b1;
            end
        end
    end

    // End of string: give the verdict and clear for the next string
    always_comb
    begin
        verdict = !upd.err && (upd.pending == 2'd0);
        if (last_in)
        begin
            state_nxt = '0;
        end
        else
        begin
            state_nxt = upd;
        end
    end

endmodule

/* rtl/utf8_string_validator_unit.sv */
// Top level of the restricted UTF-8 string validator.
// Depends on utf8v_pkg and utf8v_step.

// Takes one byte transaction per clock and returns one verdict transaction
// (string_valid) for each transaction flagged last_byte. Throughput is one
// byte per cycle. After a last byte is accepted, it sits in the input
// register, and its verdict is loaded into the result register when it
// advances. The input stalls only while a string-ending byte waits behind
// a verdict that the output side has not yet taken. A transaction with
// no_byte set adds no byte; with last_byte also set it closes the string
// (an empty string is valid). No configuration, no reset sweep.
module utf8_string_validator_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    input  logic       no_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       string_valid
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic                  none_reg;
    utf8v_pkg::dec_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  verdict_reg;
    logic                  verdict;
    logic                  advance;
    logic                  out_free;
    logic                  take_in;

    // Handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && (!last_reg || out_free);
    assign in_stall  = in_valid_reg && !advance;
    assign take_in   = in_valid && !in_stall;

    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = (advance && last_reg) || (out_valid_reg && out_stall);

    // Decode logic
    utf8v_step u_step
    (
        .state_cur (state_reg),
        .byte_in   (byte_reg),
        .last_in   (last_reg),
        .none_in   (none_reg),
        .state_nxt (state_next),
        .verdict   (verdict)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg <= byte_value;
            last_reg <= last_byte;
            none_reg <= no_byte;
        end
        if (advance && last_reg)
        begin
            verdict_reg <= verdict;
        end
    end

    assign out_valid    = out_valid_reg;
    assign string_valid = verdict_reg;

    // A string-ending transaction leaves the decoder clear for the next string
    a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (state_reg == '0))
        else $error("decoder state not cleared after end of string");

    // An error sticks until the string ends
    a_err_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.err && !(advance && last_reg)) |=> state_reg.err)
        else $error("error flag dropped mid-string");

    // A held verdict blocks a string-ending byte
    a_hold_blocks_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && in_valid_reg && last_reg) |-> in_stall)
        else $error("string end passed while verdict held");

    // Any valid verdict comes from an error-free string
    a_verdict_src : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg && state_reg.err) |=> !string_valid)
        else $error("valid verdict after error");

endmodule

/* sim/utf8_string_validator_unit_test.sv */
// Self-checking testbench for utf8_string_validator_unit.
// Needs utf8v_pkg and the validator RTL; drives byte transactions and checks
// each verdict against a behavioral model of restricted UTF-8 validation.
`timescale 1ns / 1ps

module utf8_string_validator_unit_test;

    localparam int ITEM_TARGET = 1350;
    localparam int N_DIRECTED  = 25;
    localparam int MAX_REPORTS = 10;
    localparam int CP_BITS     = utf8v_pkg::CP_W;

    // One directed row: byte transaction plus optional hand-written verdict
    typedef struct packed {
        logic [7:0] bval;
        logic       is_last;
        logic       is_none;
        logic       typed;
        logic       verdict;
    } drow_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] byte_value = 8'h00;
    logic       last_byte  = 1'b0;
    logic       no_byte    = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       string_valid;

    // Model state for the string in progress
    logic [1:0]         cont_left;
    logic [1:0]         seq_conts;
    logic [CP_BITS-1:0] code_acc;
    logic               str_bad;

    bit         expected_verdicts[$];
    logic [7:0] str_bytes[$];
    drow_t      directed_rows[N_DIRECTED];
    int         items_sent   = 0;
    int         burst_left   = 0;
    int         fail_count   = 0;
    int         report_count = 0;
    int         stall_mode   = 0;
    int         stall_left   = 0;

    utf8_string_validator_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .no_byte      (no_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .string_valid (string_valid)
    );

    always #4 clk = ~clk;

    // Queue one expected verdict
    task automatic queue_verdict(input bit v);
        expected_verdicts = {expected_verdicts, v};
    endtask

    // Append one byte to the string under construction
    task automatic put_byte(input logic [7:0] v);
        str_bytes = {str_bytes, v};
    endtask

    // Advance the model by one accepted transaction; queue the verdict on end
    task automatic track_item(input logic [7:0] b, input logic is_last,
                              input logic is_none, input bit typed, input bit verdict);
        bit overlong;
        if (!is_none && !str_bad)
        begin
            if (cont_left != utf8v_pkg::SEQ_NONE)
            begin
                if (b[7:6] != utf8v_pkg::CONT_TAG)
                    str_bad = 1'b1;
                else
                begin
                    code_acc  = {code_acc[CP_BITS-7:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == utf8v_pkg::SEQ_NONE)
                    begin
                        overlong = (seq_conts == utf8v_pkg::SEQ_ONE &&
                                    code_acc < utf8v_pkg::MIN_LEN1) ||
                                   (seq_conts == utf8v_pkg::SEQ_TWO &&
                                    code_acc < utf8v_pkg::MIN_LEN2) ||
                                   (seq_conts == utf8v_pkg::SEQ_THREE &&
                                    code_acc < utf8v_pkg::MIN_LEN3);
                        if (overlong || code_acc > utf8v_pkg::MAX_CP ||
                            (code_acc >= utf8v_pkg::SURR_LO && code_acc <= utf8v_pkg::SURR_HI))
                            str_bad = 1'b1;
                        seq_conts = utf8v_pkg::SEQ_NONE;
                        code_acc  = '0;
                    end
                end
            end
            else if (!b[7])
            begin
                if (b < utf8v_pkg::CTRL_LIMIT || b == utf8v_pkg::DEL_BYTE)
                    str_bad = 1'b1;
            end
            else if ((b & utf8v_pkg::MASK_LEAD2) == utf8v_pkg::CODE_LEAD2)
            begin
                seq_conts = utf8v_pkg::SEQ_ONE;
                code_acc  = CP_BITS'(b[4:0]);
                cont_left = utf8v_pkg::SEQ_ONE;
            end
            else if ((b & utf8v_pkg::MASK_LEAD3) == utf8v_pkg::CODE_LEAD3)
            begin
                seq_conts = utf8v_pkg::SEQ_TWO;
                code_acc  = CP_BITS'(b[3:0]);
                cont_left = utf8v_pkg::SEQ_TWO;
            end
            else if ((b & utf8v_pkg::MASK_LEAD4) == utf8v_pkg::CODE_LEAD4)
            begin
                seq_conts = utf8v_pkg::SEQ_THREE;
                code_acc  = CP_BITS'(b[2:0]);
                cont_left = utf8v_pkg::SEQ_THREE;
            end
            else
                str_bad = 1'b1;
        end
        if (is_last)
        begin
            if (typed)
                queue_verdict(verdict);
            else
                queue_verdict(!str_bad && cont_left == utf8v_pkg::SEQ_NONE);
            cont_left = utf8v_pkg::SEQ_NONE;
            seq_conts = utf8v_pkg::SEQ_NONE;
            code_acc  = '0;
            str_bad   = 1'b0;
        end
    endtask

    // Send one transaction, with random gaps between bursts
    task automatic push_item(input logic [7:0] b, input logic is_last, input logic is_none,
                             input bit typed, input bit verdict);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        in_valid   <= 1'b1;
        byte_value <= b;
        last_byte  <= is_last;
        no_byte    <= is_none;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_item(b, is_last, is_none, typed, verdict);
        if (!(is_none && !is_last))
            items_sent++;
    endtask

    // Append the UTF-8 encoding of a code point in the given byte count
    task automatic add_point(input logic [CP_BITS-1:0] cp, input int len);
        case (len)
            1: put_byte(cp[7:0]);
            2:
            begin
                put_byte({3'b110, cp[10:6]});
                put_byte({utf8v_pkg::CONT_TAG, cp[5:0]});
            end
            3:
            begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({utf8v_pkg::CONT_TAG, cp[11:6]});
                put_byte({utf8v_pkg::CONT_TAG, cp[5:0]});
            end
            default:
            begin
                put_byte({5'b11110, cp[20:18]});
                put_byte({utf8v_pkg::CONT_TAG, cp[17:12]});
                put_byte({utf8v_pkg::CONT_TAG, cp[11:6]});
                put_byte({utf8v_pkg::CONT_TAG, cp[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed characters, with a share of faults mixed in
    task automatic build_random_string();
        int                 nchars;
        int                 kind;
        int                 len;
        int                 idx;
        logic [CP_BITS-1:0] cp;
        logic [7:0]         b;
        str_bytes.delete();
        nchars = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
        for (int k = 0; k < nchars; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
                add_point(CP_BITS'($urandom_range(utf8v_pkg::CTRL_LIMIT,
                                                  utf8v_pkg::DEL_BYTE - 1)), 1);
            else if (kind < 48)
                add_point(CP_BITS'($urandom_range(utf8v_pkg::MIN_LEN1,
                                                  utf8v_pkg::MIN_LEN2 - 1)), 2);
            else if (kind < 62)
            begin
                cp = CP_BITS'($urandom_range(utf8v_pkg::MIN_LEN2, utf8v_pkg::MIN_LEN3 - 1));
                if (cp >= utf8v_pkg::SURR_LO && cp <= utf8v_pkg::SURR_HI)
                    cp = cp ^ 21'h2000;
                add_point(cp, 3);
            end
            else if (kind < 76)
                add_point(CP_BITS'($urandom_range(utf8v_pkg::MIN_LEN3, utf8v_pkg::MAX_CP)), 4);
            else if (kind < 80)
            begin
                // range edges of each multi-byte encoding length
                case ($urandom_range(0, 7))
                    0:       add_point(utf8v_pkg::MIN_LEN1, 2);
                    1:       add_point(utf8v_pkg::MIN_LEN2 - 21'd1, 2);
                    2:       add_point(utf8v_pkg::MIN_LEN2, 3);
                    3:       add_point(utf8v_pkg::SURR_LO - 21'd1, 3);
                    4:       add_point(utf8v_pkg::SURR_HI + 21'd1, 3);
                    5:       add_point(utf8v_pkg::MIN_LEN3 - 21'd1, 3);
                    6:       add_point(utf8v_pkg::MIN_LEN3, 4);
                    default: add_point(utf8v_pkg::MAX_CP, 4);
                endcase
            end
            else
            begin
                // a valid multi-byte point, used by truncation and bad-tag faults
                len = $urandom_range(2, 4);
                cp  = CP_BITS'((len == 2) ?
                          $urandom_range(utf8v_pkg::MIN_LEN1, utf8v_pkg::MIN_LEN2 - 1) :
                      (len == 3) ?
                          $urandom_range(utf8v_pkg::SURR_HI + 1, utf8v_pkg::MIN_LEN3 - 1) :
                          $urandom_range(utf8v_pkg::MIN_LEN3, utf8v_pkg::MAX_CP));
                case ($urandom_range(0, 7))
                    0: put_byte(8'($urandom_range(0, 255)));
                    1: put_byte(($urandom_range(0, 32) == 32) ? utf8v_pkg::DEL_BYTE :
                                8'($urandom_range(0, utf8v_pkg::CTRL_LIMIT - 1)));
                    2:
                    begin
                        // overlong: a small point in too many bytes
                        cp = CP_BITS'((len == 2) ? $urandom_range(0, utf8v_pkg::MIN_LEN1 - 1) :
                                      (len == 3) ? $urandom_range(0, utf8v_pkg::MIN_LEN2 - 1) :
                                                   $urandom_range(0, utf8v_pkg::MIN_LEN3 - 1));
                        add_point(cp, len);
                    end
                    3: add_point(CP_BITS'($urandom_range(utf8v_pkg::SURR_LO,
                                                         utf8v_pkg::SURR_HI)), 3);
                    4: add_point(CP_BITS'($urandom_range(utf8v_pkg::MAX_CP + 1, 21'h1fffff)), 4);
                    5:
                    begin
                        add_point(cp, len);
                        repeat ($urandom_range(1, len - 1))
                            str_bytes.delete(str_bytes.size() - 1);
                    end
                    6:
                    begin
                        add_point(cp, len);
                        idx = str_bytes.size() - 1 - int'($urandom_range(0, len - 2));
                        b   = 8'($urandom_range(0, 255));
                        if (b[7:6] == utf8v_pkg::CONT_TAG)
                            b[7] = 1'b0;
                        str_bytes[idx] = b;
                    end
                    default:
                        repeat ($urandom_range(1, 3))
                            put_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // Output side: out_stall follows one of four modes, switched at random
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 256);
            end
            stall_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ((stall_left % 8) < 3);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Verdict checker
    always @(posedge clk)
    begin : verdict_check
        bit want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected verdict transaction at %0t: got %0b",
                             $time, string_valid);
                report_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (string_valid !== want)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                        $display("verdict mismatch at %0t: expected %0b, got %0b",
                                 $time, want, string_valid);
                    report_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        drow_t r;
        bit    ends_on_none;
        int    n;

        cont_left = utf8v_pkg::SEQ_NONE;
        seq_conts = utf8v_pkg::SEQ_NONE;
        code_acc  = '0;
        str_bad   = 1'b0;

        //                 byte    last  none  typed verdict
        directed_rows = '{
            '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1},  // empty string
            '{8'h20, 1'b1, 1'b0, 1'b1, 1'b1},  // lowest printable
            '{8'h1f, 1'b1, 1'b0, 1'b1, 1'b0},  // control character
            '{8'h7f, 1'b1, 1'b0, 1'b1, 1'b0},  // DEL
            '{8'hff, 1'b1, 1'b0, 1'b1, 1'b0},  // invalid lead
            '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},  // error, then a good byte
            '{8'h41, 1'b1, 1'b0, 1'b1, 1'b0},
            '{8'hc1, 1'b0, 1'b0, 1'b0, 1'b0},  // overlong two-byte
            '{8'hbf, 1'b1, 1'b0, 1'b1, 1'b0},
            '{8'hed, 1'b0, 1'b0, 1'b0, 1'b0},  // surrogate
            '{8'ha0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h80, 1'b1, 1'b0, 1'b1, 1'b0},
            '{8'hf4, 1'b0, 1'b0, 1'b0, 1'b0},  // highest code point
            '{8'h8f, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'hbf, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'hbf, 1'b1, 1'b0, 1'b0, 1'b0},
            '{8'hf4, 1'b0, 1'b0, 1'b0, 1'b0},  // just above the range
            '{8'h90, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h80, 1'b1, 1'b0, 1'b1, 1'b0},
            '{8'hc3, 1'b0, 1'b0, 1'b0, 1'b0},  // cut short by an empty close
            '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
            '{8'ha5, 1'b0, 1'b1, 1'b0, 1'b0},  // ignored empty transaction
            '{8'he2, 1'b0, 1'b0, 1'b0, 1'b0},  // bad continuation tag
            '{8'h41, 1'b1, 1'b0, 1'b1, 1'b0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            r = directed_rows[i];
            push_item(r.bval, r.is_last, r.is_none, r.typed, r.verdict);
        end

        // Random strings, with stray empty transactions sprinkled in
        while (items_sent < ITEM_TARGET)
        begin
            build_random_string();
            n = str_bytes.size();
            ends_on_none = (n == 0) || ($urandom_range(0, 9) == 0);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0);
                push_item(str_bytes[k], !ends_on_none && k == n - 1, 1'b0, 1'b0, 1'b0);
            end
            if (ends_on_none)
                push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, 1'b0);
        end
        in_valid <= 1'b0;

        // Drain
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("[utf8_string_validator_unit] OK");
        else
            $display("[utf8_string_validator_unit] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("[utf8_string_validator_unit] ERROR");
        $finish;
    end

endmodule
